FILE: hdl/bqsf_pkg.sv
`default_nettype none
package bqsf_pkg;

    // default geometry limits
    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int DEFAULT_MAX_HEIGHT = 1024;

    // queue between classifier and accumulator
    localparam int QUEUE_DEPTH = 4;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam logic [CFG_DATA_W-1:0] FRAME_DIM_RESET = 11'd1024;

    // result field widths
    localparam int COUNT_W     = 20;
    localparam int EULER_W     = 20;
    localparam int AREA_W      = 22;
    localparam int PERIMETER_W = 21;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } t_cfg_reg;

    // bit-quad classes, code doubles as counter index
    typedef enum logic [2:0] {
        QUAD_Q0   = 3'd0,
        QUAD_Q1   = 3'd1,
        QUAD_Q2   = 3'd2,
        QUAD_Q3   = 3'd3,
        QUAD_Q4   = 3'd4,
        QUAD_DIAG = 3'd5
    } t_quad;

    localparam int NUM_QUAD = 6;

    // word handed from the classifier to the accumulator
    typedef struct packed {
        logic  win;        // a window was formed at this pixel
        logic  frame_end;  // last pixel of the frame
        t_quad cls;
    } t_quad_word;

    // classify a 2x2 window given clockwise from the top-left
    function automatic t_quad classify(input logic tl, input logic tr,
                                       input logic br, input logic bl);
        logic [2:0] n;
        t_quad      c;
        n = {2'b00, tl} + {2'b00, tr} + {2'b00, br} + {2'b00, bl};
        case (n)
            3'd0: c = QUAD_Q0;
            3'd1: c = QUAD_Q1;
            3'd2: c = (tl == br) ? QUAD_DIAG : QUAD_Q2;
            3'd3: c = QUAD_Q3;
            default: c = QUAD_Q4;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/bqsf_ram.sv
`default_nettype none
module bqsf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read-first, registered read held when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/bqsf_front.sv
`default_nettype none
module bqsf_front #(
    parameter int MAX_WIDTH  = bqsf_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = bqsf_pkg::DEFAULT_MAX_HEIGHT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [bqsf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [bqsf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_pixel_object,
    output logic                                  o_word_valid,
    output bqsf_pkg::t_quad_word                  o_word,
    input  wire logic                             i_word_ready
);

    localparam int CXW = $clog2(MAX_WIDTH);
    localparam int RYW = $clog2(MAX_HEIGHT);
    localparam int WDW = ($clog2(MAX_WIDTH + 1) > bqsf_pkg::CFG_DATA_W)
                         ? $clog2(MAX_WIDTH + 1) : bqsf_pkg::CFG_DATA_W;
    localparam int HDW = ($clog2(MAX_HEIGHT + 1) > bqsf_pkg::CFG_DATA_W)
                         ? $clog2(MAX_HEIGHT + 1) : bqsf_pkg::CFG_DATA_W;

    logic [bqsf_pkg::CFG_DATA_W-1:0] r_frame_width, r_frame_height;
    logic [CXW-1:0] r_col, n_col;
    logic [RYW-1:0] r_row, n_row;
    logic [WDW-1:0] w_raw, w_eff, last_col;
    logic [HDW-1:0] h_raw, h_eff, last_row;
    logic           row_end, frame_end, win;
    logic           in_fire, push;
    logic           r_s1_valid, r_s1_pix, r_s1_win, r_s1_fend;
    logic           r_left, r_left_above;
    logic           above;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bqsf_pkg::FRAME_DIM_RESET;
            r_frame_height <= bqsf_pkg::FRAME_DIM_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == bqsf_pkg::REG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_data;
            end else if (i_cfg_index == bqsf_pkg::REG_FRAME_HEIGHT) begin
                r_frame_height <= i_cfg_data;
            end
        end
    end

    // clamped geometry
    always_comb begin
        w_raw = WDW'(r_frame_width);
        h_raw = HDW'(r_frame_height);
        if (w_raw < WDW'(2)) begin
            w_eff = WDW'(2);
        end else if (w_raw > WDW'(MAX_WIDTH)) begin
            w_eff = WDW'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        if (h_raw < HDW'(2)) begin
            h_eff = HDW'(2);
        end else if (h_raw > HDW'(MAX_HEIGHT)) begin
            h_eff = HDW'(MAX_HEIGHT);
        end else begin
            h_eff = h_raw;
        end
        last_col = w_eff - WDW'(1);
        last_row = h_eff - HDW'(1);
    end

    // position of the incoming pixel
    always_comb begin
        row_end   = WDW'(r_col) >= last_col;
        frame_end = row_end && (HDW'(r_row) >= last_row);
        win       = (r_col != '0) && (r_row != '0);
        if (frame_end) begin
            n_col = '0;
            n_row = '0;
        end else if (row_end) begin
            n_col = '0;
            n_row = r_row + RYW'(1);
        end else begin
            n_col = r_col + CXW'(1);
            n_row = r_row;
        end
    end

    assign push       = r_s1_valid && i_word_ready;
    assign o_in_ready = !r_s1_valid || i_word_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line store of the previous row
    bqsf_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (in_fire),
        .i_waddr (r_col),
        .i_wdata (i_pixel_object),
        .i_re    (in_fire),
        .i_raddr (r_col),
        .o_rdata (above)
    );

    // classify stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pix  <= i_pixel_object;
            r_s1_win  <= win;
            r_s1_fend <= frame_end;
        end
    end

    // left neighbors, cleared at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left       <= 1'b0;
            r_left_above <= 1'b0;
        end else if (push) begin
            r_left       <= r_s1_fend ? 1'b0 : r_s1_pix;
            r_left_above <= r_s1_fend ? 1'b0 : above;
        end
    end

    assign o_word_valid     = r_s1_valid;
    assign o_word.win       = r_s1_win;
    assign o_word.frame_end = r_s1_fend;
    assign o_word.cls       = bqsf_pkg::classify(r_left_above, above, r_s1_pix, r_left);

endmodule
`default_nettype wire

FILE: hdl/bqsf_queue.sv
`default_nettype none
module bqsf_queue #(
    parameter int DEPTH = bqsf_pkg::QUEUE_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push_valid,
    output logic                      o_push_ready,
    input  wire bqsf_pkg::t_quad_word i_push_word,
    output logic                      o_pop_valid,
    input  wire logic                 i_pop_ready,
    output bqsf_pkg::t_quad_word      o_pop_word
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    bqsf_pkg::t_quad_word r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_push_ready = r_count != CW'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = o_pop_valid && i_pop_ready;
    assign o_pop_word   = r_slot[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_word;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/bqsf_back.sv
`default_nettype none
module bqsf_back #(
    parameter int MAX_WIDTH  = bqsf_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = bqsf_pkg::DEFAULT_MAX_HEIGHT
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_word_valid,
    output logic                                         o_word_ready,
    input  wire bqsf_pkg::t_quad_word                    i_word,
    output logic                                         o_out_valid,
    input  wire logic                                    i_out_ready,
    output logic        [bqsf_pkg::COUNT_W-1:0]          o_count_q0,
    output logic        [bqsf_pkg::COUNT_W-1:0]          o_count_q1,
    output logic        [bqsf_pkg::COUNT_W-1:0]          o_count_q2,
    output logic        [bqsf_pkg::COUNT_W-1:0]          o_count_q3,
    output logic        [bqsf_pkg::COUNT_W-1:0]          o_count_q4,
    output logic        [bqsf_pkg::COUNT_W-1:0]          o_count_diagonal,
    output logic signed [bqsf_pkg::EULER_W-1:0]          o_euler_number,
    output logic        [bqsf_pkg::AREA_W-1:0]           o_area_sum,
    output logic        [bqsf_pkg::PERIMETER_W-1:0]      o_perimeter_sum
);

    localparam int CW = $clog2((MAX_WIDTH - 1) * (MAX_HEIGHT - 1) + 1);
    localparam int SW = CW + 3;

    logic [CW-1:0] r_cnt  [bqsf_pkg::NUM_QUAD];
    logic [CW-1:0] n_cnt  [bqsf_pkg::NUM_QUAD];
    logic [CW-1:0] r_snap [bqsf_pkg::NUM_QUAD];
    logic          r_snap_valid, snap_adv, do_pop;
    logic [SW-1:0] e0, e1, e2, e3, e4, ed;
    logic signed [SW:0] s_diff, s_adj, s_quot;
    logic [SW-1:0] area, perim;

    assign snap_adv     = r_snap_valid && (!o_out_valid || i_out_ready);
    assign o_word_ready = !i_word.frame_end || !r_snap_valid || snap_adv;
    assign do_pop       = i_word_valid && o_word_ready;

    // counts including the popped window
    always_comb begin
        for (int k = 0; k < bqsf_pkg::NUM_QUAD; k++) begin
            if (i_word.win && (i_word.cls == bqsf_pkg::t_quad'(k))) begin
                n_cnt[k] = r_cnt[k] + CW'(1);
            end else begin
                n_cnt[k] = r_cnt[k];
            end
        end
    end

    // class counters, cleared at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < bqsf_pkg::NUM_QUAD; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (do_pop) begin
            for (int k = 0; k < bqsf_pkg::NUM_QUAD; k++) begin
                r_cnt[k] <= i_word.frame_end ? '0 : n_cnt[k];
            end
        end
    end

    // frame snapshot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (do_pop && i_word.frame_end) begin
            r_snap_valid <= 1'b1;
        end else if (snap_adv) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_pop && i_word.frame_end) begin
            for (int k = 0; k < bqsf_pkg::NUM_QUAD; k++) begin
                r_snap[k] <= n_cnt[k];
            end
        end
    end

    // derived measures
    always_comb begin
        e0     = SW'(r_snap[bqsf_pkg::QUAD_Q0]);
        e1     = SW'(r_snap[bqsf_pkg::QUAD_Q1]);
        e2     = SW'(r_snap[bqsf_pkg::QUAD_Q2]);
        e3     = SW'(r_snap[bqsf_pkg::QUAD_Q3]);
        e4     = SW'(r_snap[bqsf_pkg::QUAD_Q4]);
        ed     = SW'(r_snap[bqsf_pkg::QUAD_DIAG]);
        s_diff = $signed({1'b0, e1}) - $signed({1'b0, e3}) - $signed({1'b0, ed << 1});
        // bias negatives so the shift truncates toward zero
        s_adj  = s_diff + $signed({{(SW - 1){1'b0}}, s_diff[SW], s_diff[SW]});
        s_quot = s_adj >>> 2;
        area   = e1 + (e2 << 1) + e3 + (e3 << 1) + (e4 << 2) + (ed << 1);
        perim  = e1 + e2 + e3 + (ed << 1);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (snap_adv) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_adv) begin
            o_count_q0       <= bqsf_pkg::COUNT_W'(e0);
            o_count_q1       <= bqsf_pkg::COUNT_W'(e1);
            o_count_q2       <= bqsf_pkg::COUNT_W'(e2);
            o_count_q3       <= bqsf_pkg::COUNT_W'(e3);
            o_count_q4       <= bqsf_pkg::COUNT_W'(e4);
            o_count_diagonal <= bqsf_pkg::COUNT_W'(ed);
            o_euler_number   <= bqsf_pkg::EULER_W'(s_quot);
            o_area_sum       <= bqsf_pkg::AREA_W'(area);
            o_perimeter_sum  <= bqsf_pkg::PERIMETER_W'(perim);
        end
    end

endmodule
`default_nettype wire

FILE: hdl/bit_quad_shape_features_top.sv
`default_nettype none
// Streaming Gray bit-quad shape measures. Pixels of a binary image enter in
// raster order, one per clock, with no gaps needed and no stall from the block
// while results are taken; the line store (one read and one write per pixel, at
// the same column) and the one-window-per-pixel classifier set that rate of one
// pixel per cycle. Every 2x2 window whose bottom-right pixel arrives is classified
// (Q0..Q4 and the diagonal class) and counted; with the frame's last pixel one
// result word carries the six counts, the Euler number (q1-q3-2qd)/4 truncated
// toward zero, the area sum and the perimeter sum, valid after the classify stage,
// queue, snapshot and output register; the counters restart. A result that is not
// taken holds the output register and the next frame's result waits in a snapshot
// behind it; a third frame's last word stalls the accumulator, and the input stalls
// once the queue fills, until the oldest word leaves. Geometry registers (index 0
// width, 1 height) are clamped to 2..MAX; write them only while no pixel is in
// flight, which the block does not enforce; a mid-frame change keeps the position.
module bit_quad_shape_features_top #(
    parameter int MAX_WIDTH  = bqsf_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = bqsf_pkg::DEFAULT_MAX_HEIGHT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [bqsf_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [bqsf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_pixel_object,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic        [bqsf_pkg::COUNT_W-1:0]      o_count_q0,
    output logic        [bqsf_pkg::COUNT_W-1:0]      o_count_q1,
    output logic        [bqsf_pkg::COUNT_W-1:0]      o_count_q2,
    output logic        [bqsf_pkg::COUNT_W-1:0]      o_count_q3,
    output logic        [bqsf_pkg::COUNT_W-1:0]      o_count_q4,
    output logic        [bqsf_pkg::COUNT_W-1:0]      o_count_diagonal,
    output logic signed [bqsf_pkg::EULER_W-1:0]      o_euler_number,
    output logic        [bqsf_pkg::AREA_W-1:0]       o_area_sum,
    output logic        [bqsf_pkg::PERIMETER_W-1:0]  o_perimeter_sum
);

    logic                 front_valid, front_ready;
    bqsf_pkg::t_quad_word front_word;
    logic                 back_valid, back_ready;
    bqsf_pkg::t_quad_word back_word;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    // position tracking, line store and classification
    bqsf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pixel_object (i_pixel_object),
        .o_word_valid   (front_valid),
        .o_word         (front_word),
        .i_word_ready   (front_ready)
    );

    // decoupling queue
    bqsf_queue #(
        .DEPTH (bqsf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_word  (front_word),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_word   (back_word)
    );

    // accumulation and result formation
    bqsf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_word_valid     (back_valid),
        .o_word_ready     (back_ready),
        .i_word           (back_word),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_count_q0       (o_count_q0),
        .o_count_q1       (o_count_q1),
        .o_count_q2       (o_count_q2),
        .o_count_q3       (o_count_q3),
        .o_count_q4       (o_count_q4),
        .o_count_diagonal (o_count_diagonal),
        .o_euler_number   (o_euler_number),
        .o_area_sum       (o_area_sum),
        .o_perimeter_sum  (o_perimeter_sum)
    );

endmodule
`default_nettype wire

FILE: hdl/bqsf_checker.sv
`default_nettype none
module bqsf_checker (
    input wire logic                                    i_clk,
    input wire logic                                    i_rst_n,
    input wire logic                                    o_out_valid,
    input wire logic                                    i_out_ready,
    input wire logic        [bqsf_pkg::COUNT_W-1:0]     o_count_q0,
    input wire logic        [bqsf_pkg::COUNT_W-1:0]     o_count_q1,
    input wire logic        [bqsf_pkg::COUNT_W-1:0]     o_count_q2,
    input wire logic        [bqsf_pkg::COUNT_W-1:0]     o_count_q3,
    input wire logic        [bqsf_pkg::COUNT_W-1:0]     o_count_q4,
    input wire logic        [bqsf_pkg::COUNT_W-1:0]     o_count_diagonal,
    input wire logic signed [bqsf_pkg::EULER_W-1:0]     o_euler_number,
    input wire logic        [bqsf_pkg::AREA_W-1:0]      o_area_sum,
    input wire logic        [bqsf_pkg::PERIMETER_W-1:0] o_perimeter_sum
);

    logic [bqsf_pkg::COUNT_W-1:0] perim_chk, area_chk;

    // sums rebuilt from the reported counts, modulo the count width
    assign perim_chk = o_count_q1 + o_count_q2 + o_count_q3 + (o_count_diagonal << 1);
    assign area_chk  = o_count_q1 + (o_count_q2 << 1) + o_count_q3 + (o_count_q3 << 1)
                       + (o_count_q4 << 2) + (o_count_diagonal << 1);

    // a stalled result word stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_count_q0) && $stable(o_area_sum)
                                        && $stable(o_euler_number))
        else $error("result word changed while stalled");

    // perimeter agrees with the class counts
    a_perim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_perimeter_sum[bqsf_pkg::COUNT_W-1:0] == perim_chk)
        else $error("perimeter sum inconsistent with counts");

    // area agrees with the class counts
    a_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_area_sum[bqsf_pkg::COUNT_W-1:0] == area_chk)
        else $error("area sum inconsistent with counts");

endmodule

bind bit_quad_shape_features_top bqsf_checker u_bqsf_checker (.*);
`default_nettype wire

FILE: bench/bit_quad_shape_features_top_test.sv
`timescale 1ns / 1ps

module bit_quad_shape_features_top_test;

    localparam int MAX_W          = bqsf_pkg::DEFAULT_MAX_WIDTH;
    localparam int MAX_H          = bqsf_pkg::DEFAULT_MAX_HEIGHT;
    localparam int SETTLE_CYCLES  = 12;
    localparam int TAIL_CYCLES    = 24;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_PIXELS   = 200;
    localparam int PRESSURE_FRAMES = 4;
    localparam int WIDE_PIXELS    = 64;
    localparam longint TIMEOUT_NS = 64'd4_000_000;

    // register indexes with no register behind them
    localparam logic [bqsf_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [bqsf_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 2'd3;

    typedef struct packed {
        logic        [bqsf_pkg::COUNT_W-1:0]     q0;
        logic        [bqsf_pkg::COUNT_W-1:0]     q1;
        logic        [bqsf_pkg::COUNT_W-1:0]     q2;
        logic        [bqsf_pkg::COUNT_W-1:0]     q3;
        logic        [bqsf_pkg::COUNT_W-1:0]     q4;
        logic        [bqsf_pkg::COUNT_W-1:0]     diag;
        logic signed [bqsf_pkg::EULER_W-1:0]     euler;
        logic        [bqsf_pkg::AREA_W-1:0]      area;
        logic        [bqsf_pkg::PERIMETER_W-1:0] perim;
    } t_shape;

    typedef enum bit {STEP_REG, STEP_PIXELS} t_step_kind;

    typedef struct {
        t_step_kind                       kind;
        logic [bqsf_pkg::CFG_INDEX_W-1:0] reg_idx;
        logic [bqsf_pkg::CFG_DATA_W-1:0]  reg_data;
        int                               n;
        bit [15:0]                        bits;
        bit                               typed;
        t_shape                           want;
    } t_plan_step;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [bqsf_pkg::CFG_INDEX_W-1:0]    i_cfg_index;
    logic [bqsf_pkg::CFG_DATA_W-1:0]     i_cfg_data;
    logic                                i_in_valid;
    logic                                o_in_ready;
    logic                                i_pixel_object;
    logic                                o_out_valid;
    logic                                i_out_ready;
    logic [bqsf_pkg::COUNT_W-1:0]        o_count_q0;
    logic [bqsf_pkg::COUNT_W-1:0]        o_count_q1;
    logic [bqsf_pkg::COUNT_W-1:0]        o_count_q2;
    logic [bqsf_pkg::COUNT_W-1:0]        o_count_q3;
    logic [bqsf_pkg::COUNT_W-1:0]        o_count_q4;
    logic [bqsf_pkg::COUNT_W-1:0]        o_count_diagonal;
    logic signed [bqsf_pkg::EULER_W-1:0] o_euler_number;
    logic [bqsf_pkg::AREA_W-1:0]         o_area_sum;
    logic [bqsf_pkg::PERIMETER_W-1:0]    o_perimeter_sum;

    bit_quad_shape_features_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_pixel_object   (i_pixel_object),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_count_q0       (o_count_q0),
        .o_count_q1       (o_count_q1),
        .o_count_q2       (o_count_q2),
        .o_count_q3       (o_count_q3),
        .o_count_q4       (o_count_q4),
        .o_count_diagonal (o_count_diagonal),
        .o_euler_number   (o_euler_number),
        .o_area_sum       (o_area_sum),
        .o_perimeter_sum  (o_perimeter_sum)
    );

    // shadow of the block: geometry, raster position, line store, tallies
    logic [bqsf_pkg::CFG_DATA_W-1:0] reg_width  = bqsf_pkg::FRAME_DIM_RESET;
    logic [bqsf_pkg::CFG_DATA_W-1:0] reg_height = bqsf_pkg::FRAME_DIM_RESET;
    bit                              line_above [MAX_W];
    bit                              left_px;
    bit                              left_above_px;
    int                              col_idx;
    int                              row_idx;
    int                              tally [bqsf_pkg::NUM_QUAD];

    t_shape     pending_shapes [$];
    t_plan_step plan [$];

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_request;
    int mismatch_count;
    int pixels_sent;
    int frames_checked;
    int reg_writes;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    function automatic int dim_limit(input logic [bqsf_pkg::CFG_DATA_W-1:0] v, input int top);
        if (int'(v) < 2) return 2;
        if (int'(v) > top) return top;
        return int'(v);
    endfunction

    function automatic t_shape shape_from(input int q0, input int q1, input int q2,
                                          input int q3, input int q4, input int qd,
                                          input int e, input int area, input int perim);
        t_shape s;
        s.q0    = bqsf_pkg::COUNT_W'(q0);
        s.q1    = bqsf_pkg::COUNT_W'(q1);
        s.q2    = bqsf_pkg::COUNT_W'(q2);
        s.q3    = bqsf_pkg::COUNT_W'(q3);
        s.q4    = bqsf_pkg::COUNT_W'(q4);
        s.diag  = bqsf_pkg::COUNT_W'(qd);
        s.euler = bqsf_pkg::EULER_W'(e);
        s.area  = bqsf_pkg::AREA_W'(area);
        s.perim = bqsf_pkg::PERIMETER_W'(perim);
        return s;
    endfunction

    // advance the raster by one pixel; returns 1 with the frame totals on its last pixel
    function automatic bit step_raster(input bit px, output t_shape res);
        int              w;
        int              h;
        bit              up;
        bit              row_done;
        bit              frame_done;
        int              ones;
        int              e;
        bqsf_pkg::t_quad q;
        w = dim_limit(reg_width, MAX_W);
        h = dim_limit(reg_height, MAX_H);
        up = 1'b0;
        res = '0;
        row_done = col_idx >= w - 1;
        frame_done = row_done && row_idx >= h - 1;
        if (col_idx < MAX_W) begin
            up = line_above[col_idx];
            line_above[col_idx] = px;
        end
        // window: top-left, top-right, bottom-right, bottom-left
        if (col_idx >= 1 && row_idx >= 1) begin
            ones = int'(left_above_px) + int'(up) + int'(px) + int'(left_px);
            case (ones)
                0: q = bqsf_pkg::QUAD_Q0;
                1: q = bqsf_pkg::QUAD_Q1;
                2: q = ((left_above_px && px) || (up && left_px)) ? bqsf_pkg::QUAD_DIAG
                                                                  : bqsf_pkg::QUAD_Q2;
                3: q = bqsf_pkg::QUAD_Q3;
                default: q = bqsf_pkg::QUAD_Q4;
            endcase
            tally[q]++;
        end
        left_px = px;
        left_above_px = up;
        if (frame_done) begin
            e = (tally[bqsf_pkg::QUAD_Q1] - tally[bqsf_pkg::QUAD_Q3]
                 - 2 * tally[bqsf_pkg::QUAD_DIAG]) / 4;
            res = shape_from(tally[bqsf_pkg::QUAD_Q0], tally[bqsf_pkg::QUAD_Q1],
                             tally[bqsf_pkg::QUAD_Q2], tally[bqsf_pkg::QUAD_Q3],
                             tally[bqsf_pkg::QUAD_Q4], tally[bqsf_pkg::QUAD_DIAG], e,
                             tally[bqsf_pkg::QUAD_Q1] + 2 * tally[bqsf_pkg::QUAD_Q2]
                             + 3 * tally[bqsf_pkg::QUAD_Q3] + 4 * tally[bqsf_pkg::QUAD_Q4]
                             + 2 * tally[bqsf_pkg::QUAD_DIAG],
                             tally[bqsf_pkg::QUAD_Q1] + tally[bqsf_pkg::QUAD_Q2]
                             + tally[bqsf_pkg::QUAD_Q3] + 2 * tally[bqsf_pkg::QUAD_DIAG]);
            foreach (tally[i]) tally[i] = 0;
            col_idx = 0;
            row_idx = 0;
            left_px = 1'b0;
            left_above_px = 1'b0;
        end else if (row_done) begin
            col_idx = 0;
            row_idx++;
        end else begin
            col_idx++;
        end
        return frame_done;
    endfunction

    function automatic void add_reg(input logic [bqsf_pkg::CFG_INDEX_W-1:0] idx,
                                    input logic [bqsf_pkg::CFG_DATA_W-1:0] data);
        t_plan_step s;
        s = '{kind: STEP_REG, reg_idx: idx, reg_data: data, n: 0, bits: '0,
              typed: 1'b0, want: '0};
        plan.insert(plan.size(), s);
    endfunction

    function automatic void add_pixels(input int n, input bit [15:0] bits, input bit typed,
                                       input t_shape want);
        t_plan_step s;
        s = '{kind: STEP_PIXELS, reg_idx: '0, reg_data: '0, n: n, bits: bits,
              typed: typed, want: want};
        plan.insert(plan.size(), s);
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_shape(input t_shape got);
        t_shape want;
        if (pending_shapes.size() == 0) begin
            $display("%0t: result word with none expected, q0 %0d", $time, got.q0);
            mismatch_count++;
            return;
        end
        want = pending_shapes.pop_front();
        check_field("count_q0", longint'(want.q0), longint'(got.q0));
        check_field("count_q1", longint'(want.q1), longint'(got.q1));
        check_field("count_q2", longint'(want.q2), longint'(got.q2));
        check_field("count_q3", longint'(want.q3), longint'(got.q3));
        check_field("count_q4", longint'(want.q4), longint'(got.q4));
        check_field("count_diagonal", longint'(want.diag), longint'(got.diag));
        check_field("euler_number", longint'(want.euler), longint'(got.euler));
        check_field("area_sum", longint'(want.area), longint'(got.area));
        check_field("perimeter_sum", longint'(want.perim), longint'(got.perim));
    endtask

    // wait until every result is out and the pipeline has emptied
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (pending_shapes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bqsf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [bqsf_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == bqsf_pkg::REG_FRAME_WIDTH) reg_width = data;
        else if (idx == bqsf_pkg::REG_FRAME_HEIGHT) reg_height = data;
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one pixel word and hold it until taken
    task automatic send_pixel(input bit px, input bit use_typed, input t_shape typed);
        t_shape res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_pixel_object <= px;
        do @(posedge i_clk); while (!o_in_ready);
        pixels_sent++;
        if (step_raster(px, res)) pending_shapes.insert(pending_shapes.size(),
                                                        use_typed ? typed : res);
    endtask

    // one whole frame at the current geometry, object pixels at the given percentage
    task automatic send_frame(input int density);
        int n;
        n = dim_limit(reg_width, MAX_W) * dim_limit(reg_height, MAX_H);
        repeat (n) send_pixel($urandom_range(99) < density, 1'b0, '0);
    endtask

    task automatic run_frames(input int goal);
        int start;
        int pick;
        int density;
        start = pixels_sent;
        while (pixels_sent - start < goal) begin
            // new geometry now and then, sometimes outside the legal range
            if ($urandom_range(2) == 0) begin
                settle_block();
                pick = $urandom_range(19);
                write_reg(bqsf_pkg::REG_FRAME_WIDTH, bqsf_pkg::CFG_DATA_W'(
                          pick == 0 ? $urandom_range(1) : $urandom_range(7, 2)));
                pick = $urandom_range(19);
                write_reg(bqsf_pkg::REG_FRAME_HEIGHT, bqsf_pkg::CFG_DATA_W'(
                          pick == 0 ? $urandom_range(1) : $urandom_range(7, 2)));
                if ($urandom_range(7) == 0)
                    write_reg($urandom_range(1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                              bqsf_pkg::CFG_DATA_W'($urandom_range(2047)));
            end
            case ($urandom_range(4))
                0: density = 0;
                1: density = 100;
                default: density = $urandom_range(90, 10);
            endcase
            send_frame(density);
        end
    endtask

    // result side: check taken words, then pick next ready
    initial begin : result_sink
        int hold_left;
        t_shape got;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got = '{o_count_q0, o_count_q1, o_count_q2, o_count_q3, o_count_q4,
                        o_count_diagonal, o_euler_number, o_area_sum, o_perimeter_sum};
                check_shape(got);
                frames_checked++;
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin : pixel_source
        int k;
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= bqsf_pkg::REG_FRAME_WIDTH;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_pixel_object <= 1'b0;
        send_idle_pct = 11;
        recv_idle_pct = 86;

        // directed: clamped 2x2 geometry, unmapped indexes, class extremes
        add_reg(bqsf_pkg::REG_FRAME_WIDTH, 11'd0);
        add_reg(bqsf_pkg::REG_FRAME_HEIGHT, 11'd1);
        add_reg(REG_UNMAPPED_LO, 11'd2047);
        add_reg(REG_UNMAPPED_HI, 11'h555);
        add_pixels(4, 16'b1111, 1'b1, shape_from(0, 0, 0, 0, 1, 0, 0, 4, 0));
        add_pixels(4, 16'b0000, 1'b1, shape_from(1, 0, 0, 0, 0, 0, 0, 0, 0));
        // lone diagonal pair: euler -2/4 truncates to zero
        add_pixels(4, 16'b1001, 1'b1, shape_from(0, 0, 0, 0, 0, 1, 0, 2, 2));
        // 5x4 frame cut short mid-row: both dimensions shrink below the position
        add_reg(bqsf_pkg::REG_FRAME_WIDTH, 11'd5);
        add_reg(bqsf_pkg::REG_FRAME_HEIGHT, 11'd4);
        add_pixels(5, 16'b11001, 1'b0, '0);
        add_pixels(5, 16'b11000, 1'b0, '0);
        add_pixels(3, 16'b011, 1'b0, '0);
        add_reg(bqsf_pkg::REG_FRAME_WIDTH, 11'd1);
        add_reg(bqsf_pkg::REG_FRAME_HEIGHT, 11'd0);
        add_pixels(1, 16'b1, 1'b0, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table
        foreach (plan[i]) begin
            if (plan[i].kind == STEP_REG) begin
                settle_block();
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            end else begin
                for (k = plan[i].n - 1; k >= 0; k--)
                    send_pixel(plan[i].bits[k], plan[i].typed && k == 0, plan[i].want);
            end
        end

        // random frames: sender mostly busy with receiver mostly stalled, then the reverse, then no idling
        run_frames(PHASE_PIXELS);
        send_idle_pct = 86;
        recv_idle_pct = 11;
        run_frames(PHASE_PIXELS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_frames(PHASE_PIXELS);

        // long output hold-off while small frames keep coming, so the input backs up
        settle_block();
        write_reg(bqsf_pkg::REG_FRAME_WIDTH, 11'd4);
        write_reg(bqsf_pkg::REG_FRAME_HEIGHT, 11'd3);
        hold_request = 1'b1;
        repeat (PRESSURE_FRAMES) send_frame(50);

        // width written out of range clamps to the widest row, then shrinks mid-row
        settle_block();
        write_reg(bqsf_pkg::REG_FRAME_WIDTH, 11'd2047);
        write_reg(bqsf_pkg::REG_FRAME_HEIGHT, 11'd0);
        repeat (WIDE_PIXELS) send_pixel($urandom_range(99) < 50, 1'b0, '0);
        settle_block();
        write_reg(bqsf_pkg::REG_FRAME_WIDTH, 11'd3);
        // the long row ends on the next word, then one row of three closes the frame
        repeat (4) send_pixel($urandom_range(99) < 50, 1'b0, '0);

        settle_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("pixels sent %0d, frame results checked %0d, register writes %0d",
                 pixels_sent, frames_checked, reg_writes);
        $display("small frames under three idle mixes, clamped and mid-frame shrunk "
                 , "geometry, a 1024-wide row and an output hold-off that stalls input");
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
